// ----- sv/pbc_pkg.sv -----
// Shared types, constants and helpers for the pileup base counter.
// No dependencies; every other file of the block uses this package.
package pbc_pkg;

    localparam int CNT_W   = 16;
    localparam int FIELD_W = 16;
    localparam int SUM_W   = 19;
    localparam int NBASE   = 5;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam logic [1:0] SKIP_LEN = 2'd2;

    typedef enum logic [2:0] {
        BASE_A = 3'd0,
        BASE_C = 3'd1,
        BASE_G = 3'd2,
        BASE_T = 3'd3,
        BASE_N = 3'd4
    } t_base;

    localparam logic [1:0] STRAND_TOT = 2'd0;
    localparam logic [1:0] STRAND_FWD = 2'd1;
    localparam logic [1:0] STRAND_REV = 2'd2;

    typedef logic [NBASE-1:0][CNT_W-1:0] t_cnt_arr;

    typedef struct packed {
        logic        clear;
        logic        bump;
        logic        rev;
        logic [2:0]  code;
        logic        last;
        logic [31:0] position;
        logic [2:0]  ref_code;
    } t_cmd;

    typedef struct packed {
        t_cnt_arr    fwd;
        t_cnt_arr    rev;
        logic [31:0] position;
        logic [2:0]  ref_code;
    } t_snap;

    // upper-case ASCII to base code; anything else is N
    function automatic logic [2:0] char_code(input logic [7:0] ch);
        logic [2:0] code;
        case (ch)
            "A":     code = BASE_A;
            "C":     code = BASE_C;
            "G":     code = BASE_G;
            "T":     code = BASE_T;
            default: code = BASE_N;
        endcase
        return code;
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return w[FIELD_W-1:0];
    endfunction

endpackage

// ----- sv/pbc_front.sv -----
// Front end: accepts characters, tracks skip state, latches position and
// reference, and turns each beat into a counter command. Uses pbc_pkg.
module pbc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_full,
    input  logic           i_first,
    input  logic [31:0]    i_position,
    input  logic [7:0]     i_ref_char,
    input  logic [7:0]     i_align_char,
    input  logic           i_last,
    output logic           o_push,
    output pbc_pkg::t_cmd  o_cmd
);

    logic [1:0]  r_skip, n_skip;
    logic [2:0]  r_ref, n_ref;
    logic [31:0] r_pos, n_pos;
    logic [7:0]  ref_up;
    logic [7:0]  ch;

    assign o_push = i_valid && !i_full;
    assign ch     = i_align_char;

    always_comb begin
        ref_up = (i_ref_char >= "a" && i_ref_char <= "z") ? i_ref_char - 8'd32 : i_ref_char;
        n_skip = i_first ? 2'd0 : r_skip;
        n_ref  = i_first ? pbc_pkg::char_code(ref_up) : r_ref;
        n_pos  = i_first ? i_position : r_pos;

        o_cmd.clear    = i_first;
        o_cmd.bump     = 1'b0;
        o_cmd.rev      = 1'b0;
        o_cmd.code     = n_ref;
        o_cmd.last     = i_last;
        o_cmd.position = n_pos;
        o_cmd.ref_code = n_ref;

        if (n_skip != 2'd0) begin
            n_skip = n_skip - 2'd1;
        end else if (ch == pbc_pkg::CH_DOT) begin
            o_cmd.bump = 1'b1;
        end else if (ch == pbc_pkg::CH_COMMA) begin
            o_cmd.bump = 1'b1;
            o_cmd.rev  = 1'b1;
        end else if (ch == pbc_pkg::CH_PLUS) begin
            n_skip = pbc_pkg::SKIP_LEN;
        end else if (ch == "A" || ch == "C" || ch == "G" || ch == "T" || ch == "N") begin
            o_cmd.bump = 1'b1;
            o_cmd.code = pbc_pkg::char_code(ch);
        end else if (ch == "a" || ch == "c" || ch == "g" || ch == "t" || ch == "n") begin
            o_cmd.bump = 1'b1;
            o_cmd.rev  = 1'b1;
            o_cmd.code = pbc_pkg::char_code(ch - 8'd32);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 2'd0;
            r_ref  <= pbc_pkg::BASE_N;
            r_pos  <= 32'd0;
        end else if (o_push) begin
            r_skip <= n_skip;
            r_ref  <= n_ref;
            r_pos  <= n_pos;
        end
    end

endmodule

// ----- sv/pbc_queue.sv -----
// Short command queue between front end and counters.
// Uses pbc_pkg for the command type and depth.
module pbc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbc_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output pbc_pkg::t_cmd  o_cmd
);

    pbc_pkg::t_cmd              r_mem [pbc_pkg::Q_DEPTH];
    logic [pbc_pkg::Q_AW-1:0]   r_wr, r_rd;
    logic [pbc_pkg::Q_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (pbc_pkg::Q_AW+1)'(pbc_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + pbc_pkg::Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + pbc_pkg::Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (pbc_pkg::Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (pbc_pkg::Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- sv/pbc_counter.sv -----
// Strand counters: applies queued commands and hands a snapshot of the
// counts to the record stage at the end of each position. Uses pbc_pkg.
module pbc_counter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  pbc_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    input  logic           i_take,
    output logic           o_snap_valid,
    output pbc_pkg::t_snap o_snap
);

    pbc_pkg::t_cnt_arr r_fwd, n_fwd;
    pbc_pkg::t_cnt_arr r_rev, n_rev;
    logic              r_snap_valid;
    pbc_pkg::t_snap    r_snap;

    assign o_pop        = i_cmd_valid && (!i_cmd.last || !r_snap_valid || i_take);
    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    always_comb begin
        for (int i = 0; i < pbc_pkg::NBASE; i++) begin
            n_fwd[i] = i_cmd.clear ? '0 : r_fwd[i];
            n_rev[i] = i_cmd.clear ? '0 : r_rev[i];
            if (i_cmd.bump && i_cmd.code == 3'(i)) begin
                if (!i_cmd.rev && n_fwd[i] != pbc_pkg::CNT_MAX) begin
                    n_fwd[i] = n_fwd[i] + pbc_pkg::CNT_W'(1);
                end
                if (i_cmd.rev && n_rev[i] != pbc_pkg::CNT_MAX) begin
                    n_rev[i] = n_rev[i] + pbc_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= '0;
            r_rev <= '0;
        end else if (o_pop) begin
            r_fwd <= n_fwd;
            r_rev <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (o_pop && i_cmd.last) begin
            r_snap_valid <= 1'b1;
        end else if (i_take) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.last) begin
            r_snap.fwd      <= n_fwd;
            r_snap.rev      <= n_rev;
            r_snap.position <= i_cmd.position;
            r_snap.ref_code <= i_cmd.ref_code;
        end
    end

endmodule

// ----- sv/pbc_emit.sv -----
// Record stage: takes a count snapshot, forms the total, forward and
// reverse records and drives the registered output beat. Uses pbc_pkg.
module pbc_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_snap_valid,
    input  pbc_pkg::t_snap              i_snap,
    output logic                        o_take,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [1:0]                  o_strand_set,
    output logic [31:0]                 o_out_position,
    output logic [2:0]                  o_ref_code,
    output logic [pbc_pkg::FIELD_W-1:0] o_count_a,
    output logic [pbc_pkg::FIELD_W-1:0] o_count_c,
    output logic [pbc_pkg::FIELD_W-1:0] o_count_g,
    output logic [pbc_pkg::FIELD_W-1:0] o_count_t,
    output logic [pbc_pkg::FIELD_W-1:0] o_count_n,
    output logic [pbc_pkg::SUM_W-1:0]   o_depth_sum,
    output logic [pbc_pkg::FIELD_W-1:0] o_match_count,
    output logic [2:0]                  o_majority_base,
    output logic                        o_last_record
);

    pbc_pkg::t_cnt_arr           r_fwd, r_rev, r_tot, tot, sel;
    logic [31:0]                 r_pos;
    logic [2:0]                  r_ref;
    logic                        r_busy;
    logic [1:0]                  r_set;
    logic                        out_free;
    logic                        load;
    logic [pbc_pkg::CNT_W+2:0]   sum;
    logic [63:0]                 sum_w;
    logic [pbc_pkg::CNT_W-1:0]   best;
    logic [2:0]                  maj;

    assign out_free = !o_valid || !i_stall;
    assign load     = r_busy && out_free;
    assign o_take   = i_snap_valid && (!r_busy || (out_free && r_set == pbc_pkg::STRAND_REV));

    always_comb begin
        logic [pbc_pkg::CNT_W:0] s;
        for (int i = 0; i < pbc_pkg::NBASE; i++) begin
            s = {1'b0, i_snap.fwd[i]} + {1'b0, i_snap.rev[i]};
            tot[i] = s[pbc_pkg::CNT_W] ? pbc_pkg::CNT_MAX : s[pbc_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        case (r_set)
            pbc_pkg::STRAND_TOT: sel = r_tot;
            pbc_pkg::STRAND_FWD: sel = r_fwd;
            default:             sel = r_rev;
        endcase
        sum  = '0;
        best = '0;
        maj  = pbc_pkg::BASE_A;
        for (int i = 0; i < pbc_pkg::NBASE; i++) begin
            sum = sum + (pbc_pkg::CNT_W+3)'(sel[i]);
            if (sel[i] > best) begin
                best = sel[i];
                maj  = 3'(i);
            end
        end
        sum_w = 64'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_fwd <= i_snap.fwd;
            r_rev <= i_snap.rev;
            r_tot <= tot;
            r_pos <= i_snap.position;
            r_ref <= i_snap.ref_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_set  <= pbc_pkg::STRAND_TOT;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_set  <= pbc_pkg::STRAND_TOT;
        end else if (load) begin
            if (r_set == pbc_pkg::STRAND_REV) begin
                r_busy <= 1'b0;
            end else begin
                r_set <= r_set + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_strand_set    <= r_set;
            o_out_position  <= r_pos;
            o_ref_code      <= r_ref;
            o_count_a       <= pbc_pkg::to_field(sel[pbc_pkg::BASE_A]);
            o_count_c       <= pbc_pkg::to_field(sel[pbc_pkg::BASE_C]);
            o_count_g       <= pbc_pkg::to_field(sel[pbc_pkg::BASE_G]);
            o_count_t       <= pbc_pkg::to_field(sel[pbc_pkg::BASE_T]);
            o_count_n       <= pbc_pkg::to_field(sel[pbc_pkg::BASE_N]);
            o_depth_sum     <= sum_w[pbc_pkg::SUM_W-1:0];
            o_match_count   <= pbc_pkg::to_field(sel[r_ref]);
            o_majority_base <= maj;
            o_last_record   <= (r_set == pbc_pkg::STRAND_REV);
        end
    end

endmodule

// ----- sv/pileup_base_counter.sv -----
// Pileup base counter: one alignment character a cycle while o_stall is low, three records
// per position. The total record passes the queue, the counter snapshot and the record stage
// on its way to the output register; forward and reverse follow one a cycle while i_stall is
// low. Each position yields three records, so shorter positions fill the 4-entry queue.
// Reset is synchronous, active low: counts and skip clear, reference reads N.
// Uses pbc_pkg, pbc_front, pbc_queue, pbc_counter and pbc_emit.
module pileup_base_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_first,
    input  logic [31:0]                 i_position,
    input  logic [7:0]                  i_ref_char,
    input  logic [7:0]                  i_align_char,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_strand_set,
    output logic [31:0]                 o_out_position,
    output logic [2:0]                  o_ref_code,
    output logic [pbc_pkg::FIELD_W-1:0] o_count_a,
    output logic [pbc_pkg::FIELD_W-1:0] o_count_c,
    output logic [pbc_pkg::FIELD_W-1:0] o_count_g,
    output logic [pbc_pkg::FIELD_W-1:0] o_count_t,
    output logic [pbc_pkg::FIELD_W-1:0] o_count_n,
    output logic [pbc_pkg::SUM_W-1:0]   o_depth_sum,
    output logic [pbc_pkg::FIELD_W-1:0] o_match_count,
    output logic [2:0]                  o_majority_base,
    output logic                        o_last_record
);

    logic           push, full, q_valid, pop, take, snap_valid;
    pbc_pkg::t_cmd  push_cmd, q_cmd;
    pbc_pkg::t_snap snap;

    assign o_stall = full;

    pbc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_full       (full),
        .i_first      (i_first),
        .i_position   (i_position),
        .i_ref_char   (i_ref_char),
        .i_align_char (i_align_char),
        .i_last       (i_last),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    pbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    pbc_counter u_counter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .i_take       (take),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    pbc_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_snap_valid    (snap_valid),
        .i_snap          (snap),
        .o_take          (take),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_strand_set    (o_strand_set),
        .o_out_position  (o_out_position),
        .o_ref_code      (o_ref_code),
        .o_count_a       (o_count_a),
        .o_count_c       (o_count_c),
        .o_count_g       (o_count_g),
        .o_count_t       (o_count_t),
        .o_count_n       (o_count_n),
        .o_depth_sum     (o_depth_sum),
        .o_match_count   (o_match_count),
        .o_majority_base (o_majority_base),
        .o_last_record   (o_last_record)
    );

endmodule

// ----- bench/pileup_count_checker.sv -----
`timescale 1ns / 100ps
// Checker for pileup_base_counter: watches both channels, keeps its own tally of
// strand counts and predicts the three records of each position, then compares.
// Depends on pbc_pkg for base codes, strand codes, widths and special characters.
module pileup_count_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic                          i_first,
    input  logic [31:0]                   i_position,
    input  logic [7:0]                    i_ref_char,
    input  logic [7:0]                    i_align_char,
    input  logic                          i_last,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [1:0]                    o_strand_set,
    input  logic [31:0]                   o_out_position,
    input  logic [2:0]                    o_ref_code,
    input  logic [pbc_pkg::FIELD_W-1:0]   o_count_a,
    input  logic [pbc_pkg::FIELD_W-1:0]   o_count_c,
    input  logic [pbc_pkg::FIELD_W-1:0]   o_count_g,
    input  logic [pbc_pkg::FIELD_W-1:0]   o_count_t,
    input  logic [pbc_pkg::FIELD_W-1:0]   o_count_n,
    input  logic [pbc_pkg::SUM_W-1:0]     o_depth_sum,
    input  logic [pbc_pkg::FIELD_W-1:0]   o_match_count,
    input  logic [2:0]                    o_majority_base,
    input  logic                          o_last_record,
    output int                            o_mismatches,
    output int                            o_awaited,
    output int                            o_chars,
    output int                            o_records
);

    typedef struct packed {
        logic [1:0]                                      strand;
        logic [31:0]                                     position;
        logic [2:0]                                      ref_code;
        logic [pbc_pkg::NBASE-1:0][pbc_pkg::FIELD_W-1:0] counts;
        logic [pbc_pkg::SUM_W-1:0]                       depth;
        logic [pbc_pkg::FIELD_W-1:0]                     matched;
        logic [2:0]                                      majority;
        logic                                            is_last;
    } t_record;

    string count_names [pbc_pkg::NBASE] = '{"count_a", "count_c", "count_g", "count_t",
                                            "count_n"};

    pbc_pkg::t_cnt_arr fwd_tally;
    pbc_pkg::t_cnt_arr rev_tally;
    logic [1:0]        skip_left;
    pbc_pkg::t_base    ref_base;
    logic [31:0]       held_pos;

    t_record     awaited_records [$];
    t_record     seen;
    int          mismatches = 0;
    int          chars = 0;
    int          records = 0;

    function automatic pbc_pkg::t_base code_of(input logic [7:0] ch);
        case (ch)
            "A":     return pbc_pkg::BASE_A;
            "C":     return pbc_pkg::BASE_C;
            "G":     return pbc_pkg::BASE_G;
            "T":     return pbc_pkg::BASE_T;
            default: return pbc_pkg::BASE_N;
        endcase
    endfunction

    function automatic logic [pbc_pkg::CNT_W-1:0] plus_one(
        input logic [pbc_pkg::CNT_W-1:0] c);
        return (c == pbc_pkg::CNT_MAX) ? c : c + pbc_pkg::CNT_W'(1);
    endfunction

    function automatic t_record make_record(input logic [1:0] set,
                                            input pbc_pkg::t_cnt_arr c,
                                            input logic is_last);
        t_record                   r;
        logic [pbc_pkg::CNT_W-1:0] best;
        logic [pbc_pkg::SUM_W-1:0] sum;
        int                        i;
        r.strand   = set;
        r.position = held_pos;
        r.ref_code = ref_base;
        r.majority = pbc_pkg::BASE_A;
        best = '0;
        sum  = '0;
        for (i = 0; i < pbc_pkg::NBASE; i++) begin
            r.counts[i] = c[i];
            sum = sum + pbc_pkg::SUM_W'(c[i]);
            if (c[i] > best) begin
                best = c[i];
                r.majority = 3'(i);
            end
        end
        r.depth   = sum;
        r.matched = c[ref_base];
        r.is_last = is_last;
        return r;
    endfunction

    task automatic take_char(input logic first, input logic [31:0] pos,
                             input logic [7:0] refc, input logic [7:0] ch,
                             input logic last);
        logic [7:0]              up_ref;
        logic [pbc_pkg::CNT_W:0] wide;
        pbc_pkg::t_cnt_arr       tot;
        int                      i;
        if (first) begin
            up_ref    = (refc >= "a" && refc <= "z") ? refc - 8'd32 : refc;
            fwd_tally = '0;
            rev_tally = '0;
            skip_left = '0;
            ref_base  = code_of(up_ref);
            held_pos  = pos;
        end
        if (skip_left != 0) begin
            skip_left = skip_left - 2'd1;
        end else if (ch == pbc_pkg::CH_DOT) begin
            fwd_tally[ref_base] = plus_one(fwd_tally[ref_base]);
        end else if (ch == pbc_pkg::CH_COMMA) begin
            rev_tally[ref_base] = plus_one(rev_tally[ref_base]);
        end else if (ch == pbc_pkg::CH_PLUS) begin
            skip_left = pbc_pkg::SKIP_LEN;
        end else if (code_of(ch) != pbc_pkg::BASE_N || ch == "N") begin
            fwd_tally[code_of(ch)] = plus_one(fwd_tally[code_of(ch)]);
        end else if (code_of(ch - 8'd32) != pbc_pkg::BASE_N || ch == "n") begin
            rev_tally[code_of(ch - 8'd32)] = plus_one(rev_tally[code_of(ch - 8'd32)]);
        end
        if (last) begin
            for (i = 0; i < pbc_pkg::NBASE; i++) begin
                wide   = {1'b0, fwd_tally[i]} + {1'b0, rev_tally[i]};
                tot[i] = wide[pbc_pkg::CNT_W] ? pbc_pkg::CNT_MAX : wide[pbc_pkg::CNT_W-1:0];
            end
            awaited_records.push_back(make_record(pbc_pkg::STRAND_TOT, tot, 1'b0));
            awaited_records.push_back(make_record(pbc_pkg::STRAND_FWD, fwd_tally, 1'b0));
            awaited_records.push_back(make_record(pbc_pkg::STRAND_REV, rev_tally, 1'b1));
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("record %0d, %s: expected %0d, got %0d", records, name, want, got);
        end
    endtask

    task automatic check_record(input t_record got);
        t_record want;
        int      i;
        records++;
        if (awaited_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("record %0d arrived with nothing awaited", records);
            return;
        end
        want = awaited_records.pop_front();
        compare_field("strand_set", want.strand, got.strand);
        compare_field("out_position", want.position, got.position);
        compare_field("ref_code", want.ref_code, got.ref_code);
        for (i = 0; i < pbc_pkg::NBASE; i++)
            compare_field(count_names[i], want.counts[i], got.counts[i]);
        compare_field("depth_sum", want.depth, got.depth);
        compare_field("match_count", want.matched, got.matched);
        compare_field("majority_base", want.majority, got.majority);
        compare_field("last_record", want.is_last, got.is_last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fwd_tally = '0;
            rev_tally = '0;
            skip_left = '0;
            ref_base  = pbc_pkg::BASE_N;
            held_pos  = '0;
        end else begin
            if (i_valid && !o_stall) begin
                take_char(i_first, i_position, i_ref_char, i_align_char, i_last);
                chars++;
            end
            if (o_valid && !i_stall) begin
                seen.strand    = o_strand_set;
                seen.position  = o_out_position;
                seen.ref_code  = o_ref_code;
                seen.counts[0] = o_count_a;
                seen.counts[1] = o_count_c;
                seen.counts[2] = o_count_g;
                seen.counts[3] = o_count_t;
                seen.counts[4] = o_count_n;
                seen.depth     = o_depth_sum;
                seen.matched   = o_match_count;
                seen.majority  = o_majority_base;
                seen.is_last   = o_last_record;
                check_record(seen);
            end
        end
        o_mismatches <= mismatches;
        o_awaited    <= awaited_records.size();
        o_chars      <= chars;
        o_records    <= records;
    end

endmodule

// ----- bench/tb_pileup_base_counter.sv -----
`timescale 1ns / 100ps
// Testbench top for pileup_base_counter: clock, reset, alignment character stimulus
// and receiver back-pressure; pileup_count_checker beside the block does the checking.
// Depends on pbc_pkg, the block's RTL and pileup_count_checker.
module tb_pileup_base_counter;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 250;
    localparam int RANDOM_CHARS = 125;
    localparam int CALM_CHARS   = 30;
    localparam int DRAIN_CYCLES = 40;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          i_first = 1'b0;
    logic [31:0]                   i_position = '0;
    logic [7:0]                    i_ref_char = '0;
    logic [7:0]                    i_align_char = '0;
    logic                          i_last = 1'b0;
    logic                          i_stall = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic [1:0]                    o_strand_set;
    logic [31:0]                   o_out_position;
    logic [2:0]                    o_ref_code;
    logic [pbc_pkg::FIELD_W-1:0]   o_count_a;
    logic [pbc_pkg::FIELD_W-1:0]   o_count_c;
    logic [pbc_pkg::FIELD_W-1:0]   o_count_g;
    logic [pbc_pkg::FIELD_W-1:0]   o_count_t;
    logic [pbc_pkg::FIELD_W-1:0]   o_count_n;
    logic [pbc_pkg::SUM_W-1:0]     o_depth_sum;
    logic [pbc_pkg::FIELD_W-1:0]   o_match_count;
    logic [2:0]                    o_majority_base;
    logic                          o_last_record;
    int                            o_mismatches;
    int                            o_awaited;
    int                            o_chars;
    int                            o_records;

    bit                   calm = 1'b0;
    int                   cycles = 0;

    pileup_base_counter i_dut (.*);

    pileup_count_checker i_checker (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d records awaited", o_awaited);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off early on, none once calm
    initial begin : receiver
        int  run;
        bit  held;
        held = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (calm) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 18);
                i_stall <= ($urandom_range(0, 2) == 0);
                repeat (run) @(posedge i_clk);
                if (!held && o_records >= 3) begin
                    held = 1'b1;
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_char(input logic first, input logic [31:0] pos,
                             input logic [7:0] refc, input logic [7:0] ch,
                             input logic last);
        i_valid      <= 1'b1;
        i_first      <= first;
        i_position   <= pos;
        i_ref_char   <= refc;
        i_align_char <= ch;
        i_last       <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_char();
        string pool;
        pool = "..,,ACGTNacgtn+";
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_ref();
        string pool;
        pool = "ACGTNacgtn";
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic send_position(input int len, input logic with_first, input logic with_last);
        logic [31:0] pos;
        logic [7:0]  refc;
        int          k;
        pos  = $urandom;
        refc = pick_ref();
        for (k = 0; k < len; k++) begin
            if (k == 0)
                send_char(with_first, pos, refc, pick_char(), with_last && len == 1);
            else
                send_char(1'b0, $urandom, 8'($urandom), pick_char(), with_last && k == len - 1);
        end
    endtask

    initial begin : stimulus
        int sent;
        int len;
        int kind;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no position opened yet: reset tally, reference N, coordinate zero
        send_char(1'b0, 32'h0, 8'h00, "A", 1'b0);
        send_char(1'b0, 32'hFFFF_FFFF, 8'hFF, ".", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "g", 1'b1);
        // first and last on one beat, all-ones coordinate, lower-case reference
        send_char(1'b1, 32'hFFFF_FFFF, "g", ",", 1'b1);
        // unknown reference latches N
        send_char(1'b1, 32'h0, "x", ".", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, ",", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "n", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "N", 1'b1);
        // skips, including a plus swallowed by an earlier skip
        send_char(1'b1, 32'h0001_2345, "T", "+", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, ".", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, ",", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "T", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "+", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "+", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "A", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "t", 1'b1);
        // a pending skip does not reach into the next position
        send_char(1'b1, 32'h5555_AAAA, "A", "c", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "+", 1'b1);
        send_char(1'b1, 32'hAAAA_5555, "t", "C", 1'b0);
        // extreme bytes are ignored; ties go to the lowest code
        send_char(1'b0, 32'h0, 8'h00, 8'h00, 1'b0);
        send_char(1'b0, 32'h0, 8'h00, 8'hFF, 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "G", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, "g", 1'b0);
        send_char(1'b0, 32'h0, 8'h00, ".", 1'b1);

        // mostly well-formed positions, some without a first or a last beat
        sent = 0;
        while (sent < RANDOM_CHARS) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            kind = $urandom_range(0, 9);
            send_position(len, kind != 0, kind != 1);
            sent = sent + len;
            if (sent >= RANDOM_CHARS - CALM_CHARS)
                calm = 1'b1;
        end
        // close any open position so every character ends in records
        send_char(1'b0, $urandom, 8'($urandom), pick_char(), 1'b1);
        i_valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (o_awaited != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d characters and %0d records: directed cases and random positions,",
                 o_chars, o_records);
        $display("with idling on both sides and one %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (o_mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/pbc_pkg.sv
sv/pbc_front.sv
sv/pbc_queue.sv
sv/pbc_counter.sv
sv/pbc_emit.sv
sv/pileup_base_counter.sv
bench/pileup_count_checker.sv
bench/tb_pileup_base_counter.sv
